### rtl/core/lcfc_pkg.sv
// Shared types and constants for the length and checksum frame checker.
package lcfc_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned PosW = 9;
	localparam int unsigned HeaderBytes = 2;
	localparam logic [PosW-1:0] MaxFrameReset = PosW'(128);

	typedef enum logic [1:0] {
		STATUS_BUSY     = 2'd0,
		STATUS_GOOD     = 2'd1,
		STATUS_BAD_SUM  = 2'd2,
		STATUS_OVERRUN  = 2'd3
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] rx_byte;
		logic             restart;
	} item_t;

	typedef struct packed {
		logic [ByteW-1:0] byte_out;
		logic [PosW-1:0]  byte_position;
		status_t          frame_status;
		logic             frame_end;
		logic [PosW-1:0]  frame_length;
		logic [ByteW-1:0] message_type;
	} result_t;

endpackage

### rtl/core/lcfc_in_reg.sv
// Input register stage: captures one received word and holds it until the core takes it.
module lcfc_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lcfc_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output lcfc_pkg::item_t item_s1
);
	import lcfc_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/lcfc_frame_core.sv
// Frame tracking state and the per-word position, length and checksum logic.
module lcfc_frame_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  lcfc_pkg::item_t        item_s1,
	input  logic [lcfc_pkg::PosW-1:0] max_frame_bytes,
	output lcfc_pkg::result_t      result
);
	import lcfc_pkg::*;

	logic [PosW-1:0]  bytes_seen_q;
	logic [ByteW-1:0] sum_so_far_q;
	logic [ByteW-1:0] expected_sum_q;
	logic [PosW-1:0]  total_size_q;
	logic [ByteW-1:0] type_byte_q;

	logic [PosW-1:0]  bytes_seen_d;
	logic [ByteW-1:0] sum_so_far_d;
	logic [ByteW-1:0] expected_sum_d;
	logic [PosW-1:0]  total_size_d;
	logic [ByteW-1:0] type_byte_d;

	logic [PosW-1:0]  pos;
	logic [PosW:0]    pos_next;
	logic [ByteW-1:0] b;
	status_t          sum_status;

	always_comb begin
		b = item_s1.rx_byte;
		pos = item_s1.restart ? '0 : bytes_seen_q;
		pos_next = {1'b0, pos} + (PosW+1)'(1);

		bytes_seen_d = bytes_seen_q;
		sum_so_far_d = sum_so_far_q;
		expected_sum_d = expected_sum_q;
		total_size_d = total_size_q;
		type_byte_d = type_byte_q;

		result.byte_out = b;
		result.byte_position = pos;
		result.frame_status = STATUS_BUSY;
		result.frame_end = 1'b0;
		result.frame_length = '0;
		result.message_type = '0;
		sum_status = STATUS_BUSY;

		if (pos == '0) begin
			// checksum word opens the frame
			expected_sum_d = b;
			sum_so_far_d = '0;
			total_size_d = '0;
			type_byte_d = '0;
			bytes_seen_d = PosW'(1);
		end else if (pos == PosW'(1)) begin
			total_size_d = PosW'(b) + PosW'(HeaderBytes);
			sum_so_far_d = b;
			result.frame_length = total_size_d;
			sum_status = (b == expected_sum_q) ? STATUS_GOOD : STATUS_BAD_SUM;
			if (total_size_d > max_frame_bytes) begin
				result.frame_status = STATUS_OVERRUN;
				result.frame_end = 1'b1;
				bytes_seen_d = '0;
			end else if (b == '0) begin
				// empty payload ends the frame here
				result.frame_status = sum_status;
				result.frame_end = 1'b1;
				bytes_seen_d = '0;
			end else begin
				bytes_seen_d = PosW'(2);
			end
		end else begin
			sum_so_far_d = sum_so_far_q + b;
			if (pos == PosW'(2)) begin
				type_byte_d = b;
			end
			result.frame_length = total_size_q;
			result.message_type = type_byte_d;
			sum_status = (sum_so_far_d == expected_sum_q) ? STATUS_GOOD : STATUS_BAD_SUM;
			if (pos_next >= {1'b0, total_size_q}) begin
				result.frame_status = sum_status;
				result.frame_end = 1'b1;
				bytes_seen_d = '0;
			end else begin
				bytes_seen_d = pos_next[PosW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			sum_so_far_q <= '0;
			expected_sum_q <= '0;
			total_size_q <= '0;
			type_byte_q <= '0;
		end else if (advance) begin
			bytes_seen_q <= bytes_seen_d;
			sum_so_far_q <= sum_so_far_d;
			expected_sum_q <= expected_sum_d;
			total_size_q <= total_size_d;
			type_byte_q <= type_byte_d;
		end
	end

endmodule

### rtl/core/lcfc_out_reg.sv
// Result register: holds one finished result word until the consumer takes it.
module lcfc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lcfc_pkg::result_t  result,
	input  logic               out_ready,
	output logic               out_valid,
	output lcfc_pkg::result_t  result_q
);
	import lcfc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

### rtl/core/length_checksum_frame_checker.sv
// Top level of the length-prefixed frame checker with additive checksum.
// Checks length-prefixed frames one received word per cycle. Word 0 of a frame
// is the expected checksum, word 1 a length L (frame is L+2 words), word 2 the
// message type. Every word comes back out with its position in the frame, the
// frame length (from position 1) and the message type (from position 2). On
// the last word frame_status reports good (1) or bad checksum (2), where the
// checksum is the mod-256 sum of words 1 onward. A frame whose L+2 exceeds
// max_frame_bytes (reset 128) is flagged as overrun (3) at position 1 and
// dropped. Raising restart with a word makes that word position 0 of a new
// frame. Throughput is one word per cycle while out_ready stays high: an input
// register feeds a single pass of position/sum logic into a result register,
// so out_valid rises when the registered input word is loaded into the result
// register, and both registers keep moving while the consumer takes words.
// Write max_frame_bytes only while the block is idle; cfg_ready is always high.
module length_checksum_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       restart,
	// result words
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic [8:0] byte_position,
	output logic [1:0] frame_status,
	output logic       frame_end,
	output logic [8:0] frame_length,
	output logic [7:0] message_type,
	// configuration: max_frame_bytes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data
);
	import lcfc_pkg::*;

	logic            valid_s1;
	item_t           in_item;
	item_t           item_s1;
	logic            advance;
	result_t         result;
	result_t         result_q;
	logic [PosW-1:0] max_frame_bytes_q;

	assign in_item.rx_byte = rx_byte;
	assign in_item.restart = restart;

	// advance the stage word whenever the result register is free or draining
	assign advance = valid_s1 && (!out_valid || out_ready);

	// the limit register takes a write in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MaxFrameReset;
		end else if (cfg_valid) begin
			max_frame_bytes_q <= cfg_data;
		end
	end

	lcfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lcfc_frame_core u_frame_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item_s1         (item_s1),
		.max_frame_bytes (max_frame_bytes_q),
		.result          (result)
	);

	lcfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign byte_out = result_q.byte_out;
	assign byte_position = result_q.byte_position;
	assign frame_status = result_q.frame_status;
	assign frame_end = result_q.frame_end;
	assign frame_length = result_q.frame_length;
	assign message_type = result_q.message_type;

`ifndef SYNTHESIS
	// a frame ends exactly when a final status is reported
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (frame_status != STATUS_BUSY)))
		else $error("frame_end disagrees with frame_status");

	// overrun is only ever decided on the length word
	a_overrun_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_status == STATUS_OVERRUN) |-> (byte_position == 9'd1))
		else $error("overrun reported away from position 1");

	// the checksum word carries no length or type
	a_pos0_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_position == 9'd0) |-> (frame_length == 9'd0)
			&& (message_type == 8'd0) && !frame_end)
		else $error("position 0 word carries frame data");

	// a frame still in progress has room for at least one more word
	a_room_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_position != 9'd0) && !frame_end
			|-> ({1'b0, byte_position} + 10'd2 <= {1'b0, frame_length}))
		else $error("frame continues past its length");
`endif

endmodule
